// File: src/audio_bitcrush_sample_hold_top_macros.svh
// Assertion macros for the checker file of the bitcrusher block.
// Each macro expands to one labeled concurrent assertion clocked on clk.
`ifndef AUDIO_BITCRUSH_SAMPLE_HOLD_TOP_MACROS_SVH
`define AUDIO_BITCRUSH_SAMPLE_HOLD_TOP_MACROS_SVH

// same-cycle implication, disabled during reset
`define ABCSH_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("abcsh assertion failed");

// next-cycle implication, disabled during reset
`define ABCSH_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("abcsh assertion failed");

// next-cycle implication that also checks the reset itself
`define ABCSH_ASSERT_RST(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("abcsh assertion failed");

`endif

// File: src/abcsh_pkg.sv
// Shared types and constants for the audio bitcrusher / sample-hold block.
// No dependencies; used by every module of the block.
package abcsh_pkg;

  localparam int MAX_CHANNELS = 8;
  localparam int CH_W         = 3;
  localparam int SMP_W        = 16;
  localparam int CFG_IDX_W    = 3;
  localparam int CFG_DATA_W   = 16;
  localparam int DIV_STEPS    = 17;
  localparam int DIV_CNT_W    = 5;

  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;
  localparam cfg_idx_t REG_INTERLEAVED = 3'd0;
  localparam cfg_idx_t REG_PROCESSED   = 3'd1;
  localparam cfg_idx_t REG_GAIN        = 3'd2;
  localparam cfg_idx_t REG_LEVELS      = 3'd3;
  localparam cfg_idx_t REG_HOLD        = 3'd4;

  // request into the crush unit
  typedef struct packed {
    logic                    start;
    logic signed [SMP_W-1:0] x;
    logic [15:0]             lv;
    logic [15:0]             gain;
  } crush_req_t;

  // response from the crush unit
  typedef struct packed {
    logic                    done;
    logic signed [SMP_W-1:0] y;
  } crush_rsp_t;

  typedef enum logic [6:0] {
    C_IDLE = 7'b0000001,
    C_MUL1 = 7'b0000010,
    C_RND  = 7'b0000100,
    C_MUL2 = 7'b0001000,
    C_PREP = 7'b0010000,
    C_DIV  = 7'b0100000,
    C_DONE = 7'b1000000
  } crush_state_t;

  typedef enum logic [2:0] {
    T_IDLE = 3'b001,
    T_BUSY = 3'b010,
    T_FIN  = 3'b100
  } top_state_t;

endpackage

// File: src/abcsh_crush.sv
// Quantize, gain and saturate one sample: one shared multiplier and one
// restoring divider step, sequenced by a state machine. Uses abcsh_pkg.
module abcsh_crush (
  input  logic                   clk,
  input  logic                   rst,
  input  abcsh_pkg::crush_req_t  req,
  output abcsh_pkg::crush_rsp_t  rsp
);

  abcsh_pkg::crush_state_t state;

  logic        neg;
  logic [16:0] mag;
  logic [15:0] lv;
  logic [15:0] gain;
  logic [31:0] prod;
  logic [15:0] q;
  logic        big;
  logic [16:0] rem;
  logic [16:0] dq;
  logic [abcsh_pkg::DIV_CNT_W-1:0] cnt;

  logic [16:0] sx;
  logic [16:0] mul_a;
  logic [15:0] mul_b;
  logic [32:0] mul_p;
  logic [32:0] rnd;
  logic [40:0] dvd;
  logic [16:0] dvs;
  logic [17:0] trial;
  logic [17:0] diff;
  logic        ge;
  logic [16:0] neg_r;

  assign sx = {req.x[15], req.x};

  // shared multiplier: level scaling first, then gain
  always_comb begin
    if (state == abcsh_pkg::C_MUL1) begin
      mul_a = mag;
      mul_b = lv;
    end else begin
      mul_a = {1'b0, q};
      mul_b = gain;
    end
  end
  assign mul_p = {16'd0, mul_a} * {17'd0, mul_b};

  assign rnd   = {1'b0, prod} + 33'd16384;
  assign dvd   = {1'b0, prod, 8'h00} + {25'd0, lv};
  assign dvs   = {lv, 1'b0};
  assign trial = {rem, dq[16]};
  assign diff  = trial - {1'b0, dvs};
  assign ge    = trial >= {1'b0, dvs};
  assign neg_r = 17'd0 - dq;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= abcsh_pkg::C_IDLE;
      cnt   <= '0;
    end else begin
      case (state)
        abcsh_pkg::C_IDLE: begin
          if (req.start) begin
            neg   <= req.x[15];
            mag   <= req.x[15] ? (17'd0 - sx) : sx;
            lv    <= req.lv;
            gain  <= req.gain;
            state <= abcsh_pkg::C_MUL1;
          end
        end
        abcsh_pkg::C_MUL1: begin
          prod  <= mul_p[31:0];
          state <= abcsh_pkg::C_RND;
        end
        abcsh_pkg::C_RND: begin
          q     <= rnd[30:15];
          state <= abcsh_pkg::C_MUL2;
        end
        abcsh_pkg::C_MUL2: begin
          prod  <= mul_p[31:0];
          state <= abcsh_pkg::C_PREP;
        end
        abcsh_pkg::C_PREP: begin
          // quotient of 2^17 or more saturates either way
          big   <= dvd[40:17] >= {7'd0, dvs};
          rem   <= dvd[33:17];
          dq    <= dvd[16:0];
          cnt   <= '0;
          state <= abcsh_pkg::C_DIV;
        end
        abcsh_pkg::C_DIV: begin
          rem <= ge ? diff[16:0] : trial[16:0];
          dq  <= {dq[15:0], ge};
          if (cnt == abcsh_pkg::DIV_CNT_W'(abcsh_pkg::DIV_STEPS - 1)) begin
            state <= abcsh_pkg::C_DONE;
          end else begin
            cnt <= cnt + 1'b1;
          end
        end
        abcsh_pkg::C_DONE: begin
          state <= abcsh_pkg::C_IDLE;
        end
        default: state <= abcsh_pkg::C_IDLE;
      endcase
    end
  end

  always_comb begin
    rsp.done = (state == abcsh_pkg::C_DONE);
    if (neg) begin
      if (big || dq > 17'd32768) rsp.y = 16'sh8000;
      else                       rsp.y = neg_r[15:0];
    end else begin
      if (big || dq > 17'd32767) rsp.y = 16'sh7FFF;
      else                       rsp.y = dq[15:0];
    end
  end

endmodule

// File: src/audio_bitcrush_sample_hold_top.sv
// A degraded channel passes through abcsh_crush and its 17-step divider
// before out_valid; a pass-through channel goes straight to the output
// register. A new item is taken only once the last result is loaded there.
// Output register frees the input side while a result waits to be taken.
// rst (synchronous) restores registers to 2,2,256,256,1, clears held
// samples and the frame counter; no clearing pass is needed.
module audio_bitcrush_sample_hold_top (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic signed [abcsh_pkg::SMP_W-1:0]  sample_in,
  input  logic [abcsh_pkg::CH_W-1:0]          channel_index,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [abcsh_pkg::SMP_W-1:0]  sample_out,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [abcsh_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [abcsh_pkg::CFG_DATA_W-1:0]    cfg_data
);

  abcsh_pkg::top_state_t state;

  logic [3:0]  interleaved_channels;
  logic [3:0]  processed_channels;
  logic [15:0] gain_q8_8;
  logic [15:0] quant_levels;
  logic [7:0]  hold_frames;

  logic signed [abcsh_pkg::SMP_W-1:0] held [abcsh_pkg::MAX_CHANNELS];
  logic [7:0] frame_cnt;
  logic signed [abcsh_pkg::SMP_W-1:0] res;

  logic [3:0]  ic_eff;
  logic [3:0]  pc_lim;
  logic [3:0]  pc_eff;
  logic [15:0] lv_eff;
  logic        hold_on;
  logic        pass;
  logic        frame_end;
  logic        accept;
  logic        out_load;
  logic [7:0]  frame_cnt_inc;
  logic signed [abcsh_pkg::SMP_W-1:0] x_sel;

  abcsh_pkg::crush_req_t req;
  abcsh_pkg::crush_rsp_t rsp;

  assign cfg_ready = 1'b1;
  assign in_ready  = (state == abcsh_pkg::T_IDLE);
  assign accept    = in_valid && in_ready;
  assign out_load  = (state == abcsh_pkg::T_FIN) && (!out_valid || out_ready);

  always_comb begin
    if (interleaved_channels == 4'd0)     ic_eff = 4'd1;
    else if (interleaved_channels > 4'd8) ic_eff = 4'd8;
    else                                  ic_eff = interleaved_channels;
    pc_lim = (processed_channels > ic_eff) ? ic_eff : processed_channels;
    pc_eff = (pc_lim == 4'd0) ? 4'd1 : pc_lim;
    lv_eff = (quant_levels < 16'd2) ? 16'd2 : quant_levels;
  end

  assign hold_on       = hold_frames > 8'd1;
  assign pass          = {1'b0, channel_index} >= pc_eff;
  assign frame_end     = ({1'b0, channel_index} == (ic_eff - 4'd1)) && hold_on;
  assign frame_cnt_inc = frame_cnt + 8'd1;
  assign x_sel         = (hold_on && frame_cnt != 8'd0) ? held[channel_index] : sample_in;

  assign req.start = accept && !pass;
  assign req.x     = x_sel;
  assign req.lv    = lv_eff;
  assign req.gain  = gain_q8_8;

  abcsh_crush u_crush (
    .clk (clk),
    .rst (rst),
    .req (req),
    .rsp (rsp)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      interleaved_channels <= 4'd2;
      processed_channels   <= 4'd2;
      gain_q8_8            <= 16'd256;
      quant_levels         <= 16'd256;
      hold_frames          <= 8'd1;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        abcsh_pkg::REG_INTERLEAVED: interleaved_channels <= cfg_data[3:0];
        abcsh_pkg::REG_PROCESSED:   processed_channels   <= cfg_data[3:0];
        abcsh_pkg::REG_GAIN:        gain_q8_8            <= cfg_data;
        abcsh_pkg::REG_LEVELS:      quant_levels         <= cfg_data;
        abcsh_pkg::REG_HOLD:        hold_frames          <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  // held samples and frame counter
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < abcsh_pkg::MAX_CHANNELS; i++) begin
        held[i] <= '0;
      end
      frame_cnt <= '0;
    end else if (accept) begin
      if (!pass && hold_on && frame_cnt == 8'd0) begin
        held[channel_index] <= sample_in;
      end
      if (frame_end) begin
        frame_cnt <= (frame_cnt_inc >= hold_frames) ? 8'd0 : frame_cnt_inc;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= abcsh_pkg::T_IDLE;
    end else begin
      case (state)
        abcsh_pkg::T_IDLE: begin
          if (accept) begin
            res   <= sample_in;
            state <= pass ? abcsh_pkg::T_FIN : abcsh_pkg::T_BUSY;
          end
        end
        abcsh_pkg::T_BUSY: begin
          if (rsp.done) begin
            res   <= rsp.y;
            state <= abcsh_pkg::T_FIN;
          end
        end
        abcsh_pkg::T_FIN: begin
          if (out_load) state <= abcsh_pkg::T_IDLE;
        end
        default: state <= abcsh_pkg::T_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid  <= 1'b1;
      sample_out <= res;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

endmodule

// File: src/abcsh_checker.sv
// Port-level checks for audio_bitcrush_sample_hold_top, attached by bind.
// Depends on audio_bitcrush_sample_hold_top_macros.svh and abcsh_pkg.
`include "audio_bitcrush_sample_hold_top_macros.svh"

module abcsh_checker (
  input logic                               clk,
  input logic                               rst,
  input logic                               in_valid,
  input logic                               in_ready,
  input logic                               out_valid,
  input logic                               out_ready,
  input logic signed [abcsh_pkg::SMP_W-1:0] sample_out,
  input logic                               cfg_ready
);

  // a result waiting on the consumer must not change
  `ABCSH_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(sample_out))

  // one item at a time: busy right after a transaction
  `ABCSH_ASSERT_NEXT(a_busy_after_in, in_valid && in_ready, !in_ready)

  // no result can show up in the cycle right after a transaction
  `ABCSH_ASSERT_NEXT(a_no_early_out, in_valid && in_ready, !$rose(out_valid))

  // reset leaves the block idle and empty
  `ABCSH_ASSERT_RST(a_reset_idle, rst, in_ready && !out_valid)

  // configuration is always taken
  `ABCSH_ASSERT_NOW(a_cfg_ready, 1'b1, cfg_ready)

endmodule

bind audio_bitcrush_sample_hold_top abcsh_checker u_abcsh_checker (
  .clk        (clk),
  .rst        (rst),
  .in_valid   (in_valid),
  .in_ready   (in_ready),
  .out_valid  (out_valid),
  .out_ready  (out_ready),
  .sample_out (sample_out),
  .cfg_ready  (cfg_ready)
);

// File: bench/audio_bitcrush_sample_hold_top_tb.sv
// Testbench for audio_bitcrush_sample_hold_top: directed corners, then random settings and
// sample streams, checked against an in-bench predictor of hold, quantize, gain and saturation.
// Depends on abcsh_pkg and the RTL of the block only.
module audio_bitcrush_sample_hold_top_tb;

  localparam int QUIET_LIMIT     = 5000;
  localparam int HOLD_OFF_CYCLES = 300;
  localparam int TAIL_CYCLES     = 30;
  localparam int IDLE_PCT        = 31;

  typedef struct {
    logic signed [abcsh_pkg::SMP_W-1:0] src;
    logic [abcsh_pkg::CH_W-1:0]         ch;
    logic signed [abcsh_pkg::SMP_W-1:0] value;
  } pending_sample_t;

  logic                                clk           = 1'b0;
  logic                                rst           = 1'b1;
  logic                                in_valid      = 1'b0;
  logic signed [abcsh_pkg::SMP_W-1:0]  sample_in     = '0;
  logic [abcsh_pkg::CH_W-1:0]          channel_index = '0;
  logic                                out_ready     = 1'b0;
  logic                                cfg_valid     = 1'b0;
  logic [abcsh_pkg::CFG_IDX_W-1:0]     cfg_index     = '0;
  logic [abcsh_pkg::CFG_DATA_W-1:0]    cfg_data      = '0;
  logic                                in_ready;
  logic                                out_valid;
  logic signed [abcsh_pkg::SMP_W-1:0]  sample_out;
  logic                                cfg_ready;

  // predictor state
  logic [3:0]                          set_interleaved = 4'd2;
  logic [3:0]                          set_processed   = 4'd2;
  logic [15:0]                         set_gain        = 16'd256;
  logic [15:0]                         set_levels      = 16'd256;
  logic [7:0]                          set_hold        = 8'd1;
  logic signed [abcsh_pkg::SMP_W-1:0]  held_samples [abcsh_pkg::MAX_CHANNELS];
  logic [7:0]                          frame_count     = 8'd0;

  pending_sample_t pending_samples [$];
  int  mismatches     = 0;
  int  items_sent     = 0;
  bit  steady         = 1'b0;
  int  hold_requests  = 0;
  int  hold_served    = 0;
  int  hold_left      = 0;
  int  quiet_cycles   = 0;

  audio_bitcrush_sample_hold_top DUT (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .sample_in     (sample_in),
    .channel_index (channel_index),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .sample_out    (sample_out),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic int frame_width();
    if (set_interleaved == 0) return 1;
    if (set_interleaved > 8) return 8;
    return set_interleaved;
  endfunction

  // round to multiples of 1/levels, apply Q8.8 gain, saturate
  function automatic logic signed [abcsh_pkg::SMP_W-1:0] crush_value(
      logic signed [abcsh_pkg::SMP_W-1:0] s);
    longint unsigned lv, mag, q, num, r;
    int sv;
    sv  = s;
    lv  = (set_levels < 2) ? 2 : set_levels;
    mag = (sv < 0) ? -sv : sv;
    q   = (mag * lv + 16384) >> 15;
    num = q * set_gain * 128;
    r   = (2 * num + lv) / (2 * lv);
    if (sv < 0) return (r > 32768) ? 16'h8000 : 16'(0 - r);
    return (r > 32767) ? 16'h7FFF : 16'(r);
  endfunction

  function automatic logic signed [abcsh_pkg::SMP_W-1:0] degrade_sample(
      logic signed [abcsh_pkg::SMP_W-1:0] s, logic [abcsh_pkg::CH_W-1:0] ch);
    int ic, pc, hold_len;
    logic signed [abcsh_pkg::SMP_W-1:0] x;
    logic signed [abcsh_pkg::SMP_W-1:0] res;
    ic = frame_width();
    pc = (set_processed > ic) ? ic : set_processed;
    if (pc < 1) pc = 1;
    hold_len = (set_hold == 0) ? 1 : set_hold;
    res = s;
    if (ch < pc) begin
      x = s;
      if (hold_len > 1) begin
        if (frame_count == 0) held_samples[ch] = s;
        x = held_samples[ch];
      end
      res = crush_value(x);
    end
    // only the last interleaved channel closes a frame
    if (ch == ic - 1 && hold_len > 1) begin
      frame_count = frame_count + 8'd1;
      if (frame_count >= hold_len) frame_count = 8'd0;
    end
    return res;
  endfunction

  task automatic write_reg(abcsh_pkg::cfg_idx_t idx, logic [15:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      abcsh_pkg::REG_INTERLEAVED: set_interleaved = data[3:0];
      abcsh_pkg::REG_PROCESSED:   set_processed   = data[3:0];
      abcsh_pkg::REG_GAIN:        set_gain        = data;
      abcsh_pkg::REG_LEVELS:      set_levels      = data;
      abcsh_pkg::REG_HOLD:        set_hold        = data[7:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic write_settings(logic [3:0] ic, logic [3:0] pc, logic [15:0] gain,
                                logic [15:0] levels, logic [7:0] hold);
    write_reg(abcsh_pkg::REG_INTERLEAVED, 16'(ic));
    write_reg(abcsh_pkg::REG_PROCESSED, 16'(pc));
    write_reg(abcsh_pkg::REG_GAIN, gain);
    write_reg(abcsh_pkg::REG_LEVELS, levels);
    write_reg(abcsh_pkg::REG_HOLD, 16'(hold));
  endtask

  task automatic send_sample(logic signed [abcsh_pkg::SMP_W-1:0] s,
                             logic [abcsh_pkg::CH_W-1:0] ch);
    pending_sample_t p;
    @(negedge clk);
    while (!steady && $urandom_range(0, 99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid      <= 1'b1;
    sample_in     <= s;
    channel_index <= ch;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    p.src   = s;
    p.ch    = ch;
    p.value = degrade_sample(s, ch);
    pending_samples.push_back(p);
    items_sent++;
  endtask

  // stop offering and let every result come back
  task automatic settle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_samples.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  function automatic logic signed [abcsh_pkg::SMP_W-1:0] random_sample();
    case ($urandom_range(0, 9))
      0: return 16'h8000;
      1: return 16'h7FFF;
      2: return 16'($urandom_range(0, 64)) - 16'sd32;
      default: return 16'($urandom);
    endcase
  endfunction

  // mostly whole frames in channel order, with stray and cut-short frames mixed in
  task automatic send_stream(int n);
    int count, len, r;
    count = 0;
    while (count < n) begin
      r = $urandom_range(0, 99);
      if (r < 12) begin
        send_sample(random_sample(), 3'($urandom_range(0, 7)));
        count++;
      end else begin
        len = (r < 20) ? $urandom_range(1, frame_width()) : frame_width();
        for (int c = 0; c < len; c++) send_sample(random_sample(), 3'(c));
        count += len;
      end
    end
  endtask

  task automatic randomize_settings();
    logic [3:0]  ic, pc;
    logic [15:0] gain, levels;
    logic [7:0]  hold;
    ic = ($urandom_range(0, 9) == 0) ? 4'($urandom_range(0, 15)) : 4'($urandom_range(1, 8));
    pc = ($urandom_range(0, 9) == 0) ? 4'($urandom_range(0, 15)) : 4'($urandom_range(1, 8));
    case ($urandom_range(0, 5))
      0: gain = 16'd0;
      1: gain = 16'hFFFF;
      2: gain = 16'd256;
      3: gain = 16'($urandom_range(128, 512));
      default: gain = 16'($urandom);
    endcase
    case ($urandom_range(0, 6))
      0: levels = 16'($urandom_range(0, 1));
      1: levels = 16'hFFFF;
      2: levels = 16'd32768;
      3: levels = 16'd2;
      4: levels = 16'(1 << $urandom_range(1, 15));
      default: levels = 16'($urandom_range(2, 32768));
    endcase
    case ($urandom_range(0, 7))
      0: hold = 8'd0;
      1: hold = 8'd1;
      2: hold = 8'd255;
      3, 4, 5: hold = 8'($urandom_range(2, 4));
      default: hold = 8'($urandom_range(1, 20));
    endcase
    write_settings(ic, pc, gain, levels, hold);
  endtask

  task automatic test_reset_defaults();
    send_sample(16'h8000, 3'd0);
    send_sample(16'h7FFF, 3'd1);
    send_sample(16'sd64, 3'd0);   // exactly half a step, rounds away from zero
    send_sample(-16'sd64, 3'd1);
    send_sample(16'sd0, 3'd0);
    send_sample(16'sd12345, 3'd5); // channel beyond the frame passes through
    send_sample(-16'sd1, 3'd7);
    send_sample(16'h8000, 3'd2);
    settle();
  endtask

  task automatic test_register_corners();
    // zero channel counts, zero hold and one level all fall back to their minimum
    write_settings(4'd0, 4'd0, 16'hFFFF, 16'd1, 8'd0);
    send_sample(16'h7FFF, 3'd0);
    send_sample(16'h8000, 3'd0);
    send_sample(16'sd100, 3'd3);
    send_sample(-16'sd1, 3'd0);
    settle();
    // counts above eight clamp to eight; processed above interleaved clamps too
    write_settings(4'd15, 4'd15, 16'hFFFF, 16'hFFFF, 8'd255);
    for (int c = 0; c < 8; c++) send_sample((c % 2) ? 16'h7FFF : 16'h8000, 3'(c));
    settle();
    // two-frame hold on channel 0, channel 1 unprocessed
    write_settings(4'd2, 4'd1, 16'd256, 16'd32768, 8'd2);
    for (int f = 0; f < 3; f++) begin
      send_sample(16'(1000 * (f + 1)), 3'd0);
      send_sample(16'(-7 * (f + 1)), 3'd1);
    end
    settle();
  endtask

  task automatic test_random_settings(int phases, int per_phase);
    for (int p = 0; p < phases; p++) begin
      randomize_settings();
      send_stream(per_phase);
      settle();
    end
  endtask

  task automatic test_unbroken_stream();
    randomize_settings();
    steady = 1'b1;
    send_stream(100);
    settle();
    steady = 1'b0;
  endtask

  task automatic test_output_backpressure();
    randomize_settings();
    hold_requests++;
    send_stream(60);
    settle();
  endtask

  initial begin
    for (int i = 0; i < abcsh_pkg::MAX_CHANNELS; i++) held_samples[i] = '0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_reset_defaults();
    test_register_corners();
    test_random_settings(10, 100);
    test_unbroken_stream();
    test_output_backpressure();
    settle();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatches == 0 && pending_samples.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  // receiver: random stalls, steady stretches, and a long hold-off on request
  always @(negedge clk) begin
    if (hold_left > 0) begin
      out_ready <= 1'b0;
      hold_left = hold_left - 1;
    end else if (hold_served != hold_requests) begin
      hold_served = hold_served + 1;
      hold_left   = HOLD_OFF_CYCLES;
      out_ready <= 1'b0;
    end else if (steady) begin
      out_ready <= 1'b1;
    end else begin
      out_ready <= ($urandom_range(0, 99) >= IDLE_PCT);
    end
  end

  always @(posedge clk) begin
    pending_sample_t p;
    if (!rst && out_valid && out_ready) begin
      if (pending_samples.size() == 0) begin
        $display("%0t: unexpected sample_out transaction, actual %0d", $time, sample_out);
        mismatches++;
      end else begin
        p = pending_samples.pop_front();
        if (sample_out !== p.value) begin
          $display("%0t: sample_out mismatch (in %0d ch %0d): expected %0d, actual %0d",
                   $time, p.src, p.ch, p.value, sample_out);
          mismatches++;
        end
      end
    end
  end

  // watchdog on cycles without any transaction
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles == QUIET_LIMIT) begin
      $display("%0t: timeout, no transaction for %0d cycles", $time, QUIET_LIMIT);
      $display("*** FAILED ***");
      $finish;
    end
  end

endmodule

// File: audio_bitcrush_sample_hold_top.f
+incdir+src
src/abcsh_pkg.sv
src/abcsh_crush.sv
src/audio_bitcrush_sample_hold_top.sv
src/abcsh_checker.sv
bench/audio_bitcrush_sample_hold_top_tb.sv
